// ----- design/cms_pkg.sv -----
// shared types, constants and crc helpers for the count-min sketch block
// no dependencies
`default_nettype none

package cms_pkg;

    localparam int NUM_ROWS  = 3;
    localparam int CRC_W     = 32;
    localparam int CNT_W     = 32;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] KEY_MAX_BYTES = 4'd8;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX       = 32'hFFFF_FFFF;

    // reset polynomials, normal form
    localparam logic [CRC_W-1:0] POLY_ROW0_RST = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] POLY_ROW1_RST = 32'h1EDC_6F41;
    localparam logic [CRC_W-1:0] POLY_ROW2_RST = 32'hA833_982B;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ROW2 = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_UPDATE,
        S_MIN
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic hash_step;
        logic mem_read;
        logic mem_write;
        logic min_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_drop;
        logic in_empty;
        logic hash_last;
        logic is_query;
        logic out_free;
    } t_status;

    function automatic logic [CRC_W-1:0] bit_rev32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // one byte of a reflected crc, eight shift steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0]       data,
                                                  input logic [CRC_W-1:0] rpoly);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'h0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/cms_in_if.sv -----
// request channel carrying one sketch operation
// depends on cms_pkg
`default_nettype none

interface cms_in_if
    import cms_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [KEY_W-1:0]       key_bytes;
    logic [LEN_W-1:0]       key_len;

    modport source (output valid, output func, output key_bytes, output key_len,
                    input ready);
    modport sink   (input valid, input func, input key_bytes, input key_len,
                    output ready);
endinterface

`default_nettype wire

// ----- design/cms_out_if.sv -----
// result channel carrying one query estimate
// depends on cms_pkg
`default_nettype none

interface cms_out_if
    import cms_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
endinterface

`default_nettype wire

// ----- design/cms_cfg_if.sv -----
// configuration write channel: register index and write data
// depends on cms_pkg
`default_nettype none

interface cms_cfg_if
    import cms_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CRC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/cms_ctrl.sv -----
// controller state machine: clearing sweep, hashing, read-modify-write, query result
// depends on cms_pkg
`default_nettype none

module cms_ctrl
    import cms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // an oversize insert is dropped right here
                    if (i_status.in_drop) begin
                        n_state = S_IDLE;
                    end else if (i_status.in_empty) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_status.hash_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.is_query) begin
                    o_cmd.min_step = 1'b1;
                    n_state        = S_MIN;
                end else begin
                    o_cmd.mem_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_MIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/cms_datapath.sv -----
// datapath: polynomial registers, three crc units, counter memories, min and output register
// depends on cms_pkg
`default_nettype none

module cms_datapath
    import cms_pkg::*;
#(
    parameter int ROW_DEPTH = 2048
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_in_func,
    input  wire logic [KEY_W-1:0]     i_in_key_bytes,
    input  wire logic [LEN_W-1:0]     i_in_key_len,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CRC_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [CNT_W-1:0]          o_out_estimate
);

    localparam int IDX_W = $clog2(ROW_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ROW_DEPTH - 1);

    logic [CRC_W-1:0] r_poly [NUM_ROWS];
    logic [CRC_W-1:0] r_crc  [NUM_ROWS];
    logic [CNT_W-1:0] r_rd_data [NUM_ROWS];
    logic [IDX_W-1:0] w_idx  [NUM_ROWS];
    logic [IDX_W-1:0] r_clr_addr;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_left;
    logic             r_func;
    logic [CNT_W-1:0] r_m01;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_estimate;
    logic [LEN_W-1:0] w_len_sat;
    logic [CNT_W-1:0] w_min;

    // configuration registers, writable at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly[0] <= POLY_ROW0_RST;
            r_poly[1] <= POLY_ROW1_RST;
            r_poly[2] <= POLY_ROW2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLY_ROW0: r_poly[0] <= i_cfg_data;
                CFG_POLY_ROW1: r_poly[1] <= i_cfg_data;
                CFG_POLY_ROW2: r_poly[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_len_sat = (i_in_key_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : i_in_key_len;

    // key is shifted down one byte per hash step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_func;
            r_key  <= i_in_key_bytes;
            r_left <= w_len_sat;
        end else if (i_cmd.hash_step) begin
            r_key  <= r_key >> 8;
            r_left <= r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
        logic [CNT_W-1:0] r_mem [ROW_DEPTH];
        logic [CRC_W-1:0] w_hash;
        logic [CNT_W-1:0] w_inc;
        logic             w_we;
        logic [IDX_W-1:0] w_waddr;
        logic [CNT_W-1:0] w_wdata;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_crc[g] <= CRC_ALL_ONES;
            end else if (i_cmd.hash_step) begin
                r_crc[g] <= crc_byte(r_crc[g], r_key[7:0], bit_rev32(r_poly[g]));
            end
        end

        assign w_hash   = r_crc[g] ^ CRC_ALL_ONES;
        assign w_idx[g] = w_hash[IDX_W-1:0] & IDX_MASK;

        // saturating increment
        assign w_inc   = (r_rd_data[g] == CNT_MAX) ? r_rd_data[g] : r_rd_data[g] + CNT_W'(1);
        assign w_we    = i_cmd.clear || i_cmd.mem_write;
        assign w_waddr = i_cmd.clear ? r_clr_addr : w_idx[g];
        assign w_wdata = i_cmd.clear ? '0 : w_inc;

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_waddr] <= w_wdata;
            end
            if (i_cmd.mem_read) begin
                r_rd_data[g] <= r_mem[w_idx[g]];
            end
        end
    end

    // minimum in two steps: rows zero and one, then row two
    always_ff @(posedge i_clk) begin
        if (i_cmd.min_step) begin
            r_m01 <= (r_rd_data[1] < r_rd_data[0]) ? r_rd_data[1] : r_rd_data[0];
        end
    end

    assign w_min = (r_rd_data[2] < r_m01) ? r_rd_data[2] : r_m01;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_estimate <= w_min;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_estimate = r_estimate;

    always_comb begin
        o_status           = '0;
        o_status.clr_last  = (r_clr_addr == IDX_MASK);
        o_status.in_drop   = (i_in_func == FUNC_INSERT) && (i_in_key_len > KEY_MAX_BYTES);
        o_status.in_empty  = (i_in_key_len == '0);
        o_status.hash_last = (r_left == LEN_W'(1));
        o_status.is_query  = (r_func == FUNC_QUERY);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

// ----- design/count_min_sketch_crc_hashed_top.sv -----
// count-min sketch, three crc-32 hashed rows of ROW_DEPTH saturating counters
// steps: key load, one crc byte per cycle, a memory read, then an update step in which an
// insert writes the counters and a query takes its first min step; a query then loads the
// minimum into the output register, and a full output stalls it; one request at a time, a new
// one only when the last is done; reset: counters are cleared by a sweep, one address of all
// rows per cycle; no request is taken during the sweep, configuration writes are always taken
`default_nettype none

module count_min_sketch_crc_hashed_top
    import cms_pkg::*;
#(
    parameter int ROW_DEPTH = 2048
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cms_in_if.sink     i_in,
    cms_cfg_if.sink    i_cfg,
    cms_out_if.source  o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    cms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cms_datapath #(
        .ROW_DEPTH (ROW_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_in_func      (i_in.func),
        .i_in_key_bytes (i_in.key_bytes),
        .i_in_key_len   (i_in.key_len),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_estimate (o_out.estimate)
    );

endmodule

`default_nettype wire
